>>> design/psfp_pkg.sv
// psfp_pkg: types and constants for the particle sensor frame parser
// no dependencies; imported by the interfaces and every module of the block

package psfp_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'h42;
    localparam logic [7:0] HDR_SECOND = 8'h4D;

    localparam int POS_W    = 6;
    localparam int READINGS = 12;
    localparam int IDX_W    = $clog2(READINGS);

    // frame byte positions
    localparam logic [POS_W-1:0] POS_HUNT        = 6'd0;
    localparam logic [POS_W-1:0] POS_HDR2        = 6'd1;
    localparam logic [POS_W-1:0] POS_FIRST_READ  = 6'd4;
    localparam logic [POS_W-1:0] POS_LAST_READ   = 6'd27;
    localparam logic [POS_W-1:0] POS_SUM_END     = 6'd30;
    localparam logic [POS_W-1:0] POS_LAST        = 6'd31;

    // reading slots in frame order
    localparam logic [IDX_W-1:0] IDX_PM1_STD  = 4'd0;
    localparam logic [IDX_W-1:0] IDX_PM25_STD = 4'd1;
    localparam logic [IDX_W-1:0] IDX_PM10_STD = 4'd2;
    localparam logic [IDX_W-1:0] IDX_PM1_ATM  = 4'd3;
    localparam logic [IDX_W-1:0] IDX_PM25_ATM = 4'd4;
    localparam logic [IDX_W-1:0] IDX_PM10_ATM = 4'd5;
    localparam logic [IDX_W-1:0] IDX_CNT_0P3  = 4'd6;
    localparam logic [IDX_W-1:0] IDX_CNT_0P5  = 4'd7;
    localparam logic [IDX_W-1:0] IDX_CNT_1P0  = 4'd8;
    localparam logic [IDX_W-1:0] IDX_CNT_2P5  = 4'd9;
    localparam logic [IDX_W-1:0] IDX_CNT_5P0  = 4'd10;
    localparam logic [IDX_W-1:0] IDX_CNT_10P0 = 4'd11;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] word_t;

    typedef struct packed {
        word_t pm1_standard;
        word_t pm25_standard;
        word_t pm10_standard;
        word_t pm1_atmospheric;
        word_t pm25_atmospheric;
        word_t pm10_atmospheric;
        word_t count_over_0p3;
        word_t count_over_0p5;
        word_t count_over_1p0;
        word_t count_over_2p5;
        word_t count_over_5p0;
        word_t count_over_10p0;
    } readings_t;

    // frame parser to output stage
    typedef struct packed {
        logic      done;
        readings_t readings;
    } frame_result_t;

endpackage

>>> design/psfp_byte_if.sv
// psfp_byte_if, psfp_result_if: valid/ready channels of the frame parser
// depends on psfp_pkg

interface psfp_byte_if;
    import psfp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface psfp_result_if;
    import psfp_pkg::*;

    logic      valid;
    logic      ready;
    readings_t readings;

    modport source (output valid, output readings, input ready);
    modport sink   (input valid, input readings, output ready);
endinterface

>>> design/psfp_frame_ctrl.sv
// psfp_frame_ctrl: header hunt, byte position, running sum and reading store
// depends on psfp_pkg

module psfp_frame_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  psfp_pkg::byte_t         rx_byte,
    output psfp_pkg::frame_result_t result
);
    import psfp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    word_t            sum_reg, sum_next;
    byte_t            hold_reg, hold_next;
    byte_t            exp_hi_reg, exp_hi_next;
    word_t            store_reg [READINGS];
    logic             store_we;
    logic [IDX_W-1:0] store_idx;
    logic             done;

    // odd position 5..27 maps to slot (pos - 4) / 2
    assign store_idx = IDX_W'(pos_reg[4:1] - 4'd2);

    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        hold_next   = hold_reg;
        exp_hi_next = exp_hi_reg;
        store_we    = 1'b0;
        done        = 1'b0;
        if (accept)
        begin
            if (pos_reg == POS_HUNT)
            begin
                if (rx_byte == HDR_FIRST)
                begin
                    sum_next = word_t'(rx_byte);
                    pos_next = POS_HDR2;
                end
            end
            else if (pos_reg == POS_HDR2)
            begin
                if (rx_byte == HDR_SECOND)
                begin
                    sum_next = sum_reg + word_t'(rx_byte);
                    pos_next = pos_reg + 1'b1;
                end
                else if (rx_byte == HDR_FIRST)
                begin
                    // 0x42 0x42: restart on the second one
                    sum_next = word_t'(rx_byte);
                    pos_next = POS_HDR2;
                end
                else
                begin
                    pos_next = POS_HUNT;
                end
            end
            else if (pos_reg < POS_SUM_END)
            begin
                sum_next = sum_reg + word_t'(rx_byte);
                if (pos_reg >= POS_FIRST_READ && pos_reg <= POS_LAST_READ)
                begin
                    if (!pos_reg[0])
                        hold_next = rx_byte;
                    else
                        store_we = 1'b1;
                end
                pos_next = pos_reg + 1'b1;
            end
            else if (pos_reg == POS_SUM_END)
            begin
                exp_hi_next = rx_byte;
                pos_next    = pos_reg + 1'b1;
            end
            else
            begin
                pos_next = POS_HUNT;
                done     = (pos_reg == POS_LAST) && ({exp_hi_reg, rx_byte} == sum_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_HUNT;
            sum_reg    <= '0;
            hold_reg   <= '0;
            exp_hi_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            hold_reg   <= hold_next;
            exp_hi_reg <= exp_hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_reg[store_idx] <= {hold_reg, rx_byte};
    end

    always_comb
    begin
        result.done                      = done;
        result.readings.pm1_standard     = store_reg[IDX_PM1_STD];
        result.readings.pm25_standard    = store_reg[IDX_PM25_STD];
        result.readings.pm10_standard    = store_reg[IDX_PM10_STD];
        result.readings.pm1_atmospheric  = store_reg[IDX_PM1_ATM];
        result.readings.pm25_atmospheric = store_reg[IDX_PM25_ATM];
        result.readings.pm10_atmospheric = store_reg[IDX_PM10_ATM];
        result.readings.count_over_0p3   = store_reg[IDX_CNT_0P3];
        result.readings.count_over_0p5   = store_reg[IDX_CNT_0P5];
        result.readings.count_over_1p0   = store_reg[IDX_CNT_1P0];
        result.readings.count_over_2p5   = store_reg[IDX_CNT_2P5];
        result.readings.count_over_5p0   = store_reg[IDX_CNT_5P0];
        result.readings.count_over_10p0  = store_reg[IDX_CNT_10P0];
    end

endmodule

>>> design/psfp_out_stage.sv
// psfp_out_stage: result register with valid/ready toward the consumer
// depends on psfp_pkg and psfp_result_if

module psfp_out_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  psfp_pkg::frame_result_t frame,
    output logic                    room,
    psfp_result_if.source           result
);
    import psfp_pkg::*;

    logic      valid_reg, valid_next;
    readings_t data_reg;

    // a new result may land when the stage is empty or drains this cycle
    assign room = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (result.ready)
            valid_next = 1'b0;
        if (frame.done)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (frame.done)
            data_reg <= frame.readings;
    end

    assign result.valid    = valid_reg;
    assign result.readings = data_reg;

endmodule

>>> design/particle_sensor_frame_parser.sv
// particle_sensor_frame_parser: top level of the 32-byte particle sensor frame parser
// depends on psfp_pkg, psfp_byte_if/psfp_result_if, psfp_frame_ctrl, psfp_out_stage
//
//   channel  | dir | payload                      | item
//   rx       | in  | rx_byte (8 bits)             | one received serial byte
//   result   | out | readings (12 x 16-bit words) | one frame with a good checksum
//
// one byte is taken every cycle while rx.ready is high; the frame ends on its
// 32nd byte and the result shows on the output in the cycle after that byte is accepted
// rx.ready drops only while a finished result waits and result.ready is low
// reset leaves the parser hunting for the header with the output empty

module particle_sensor_frame_parser (
    input  logic          clk,
    input  logic          rst_n,
    psfp_byte_if.sink     rx,
    psfp_result_if.source result
);
    import psfp_pkg::*;

    frame_result_t frame;
    logic          room;
    logic          accept;

    assign rx.ready = room;
    assign accept   = rx.valid && room;

    psfp_frame_ctrl u_frame_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx.rx_byte),
        .result  (frame)
    );

    psfp_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame),
        .room   (room),
        .result (result)
    );

endmodule
